// File: design/mne_pkg.sv
package mne_pkg;

  // Default depth of the row-sum store
  localparam int MAX_ROWS_DEF = 1024;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register field widths
  localparam int KIND_W    = 2;
  localparam int ROW_CNT_W = 11;
  localparam int COL_CNT_W = 16;

  // Element and result widths
  localparam int ELEM_W = 32;
  localparam int ACC_W  = 64;
  localparam int ROOT_W = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_MAX  = 2'd0,
    KIND_ONE  = 2'd1,
    KIND_INF  = 2'd2,
    KIND_FROB = 2'd3
  } norm_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORM_KIND = 2'd0,
    REG_ROW_COUNT = 2'd1,
    REG_COL_COUNT = 2'd2
  } cfg_reg_t;

  // Classification of one element, passed from front to back
  typedef struct packed {
    norm_kind_t kind;
    logic       last_row;
    logic       last_col;
    logic       col_zero;
  } mne_tag_t;

  localparam int TAG_W = $bits(mne_tag_t);

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_MUL,
    FR_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MAG,
    BK_ACC,
    BK_FROB,
    BK_EMIT
  } back_state_t;

endpackage

// File: design/mne_ram.sv
module mne_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/mne_sqrt.sv
module mne_sqrt import mne_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [ACC_W-1:0]  value,
  output logic              busy,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int STEPS = ROOT_W;
  localparam int CNT_W = $clog2(STEPS + 1);
  localparam int REM_W = ROOT_W + 2;

  logic [ACC_W-1:0]  rad_r, rad_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;

  // One result bit per cycle: bring down two radicand bits and try a subtract.
  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r, rad_r[ACC_W-1 -: 2]};
    trial    = {2'b00, root_r, 2'b01};
    if (start) begin
      rad_nxt  = value;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CNT_W'(STEPS);
    end else if (cnt_r != '0) begin
      rad_nxt = {rad_r[ACC_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = REM_W'(rem_sh - trial);
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = REM_W'(rem_sh);
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = (cnt_r != '0);
  assign done = done_r;
  assign root = root_r;

endmodule

// File: design/mne_queue.sv
module mne_queue #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = mem_r[rd_ptr_r];

  // Occupancy follows pushes and pops.
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// File: design/mne_front.sv
module mne_front import mne_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int RW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ELEM_W-1:0]    in_elem_real,
  input  logic [ELEM_W-1:0]    in_elem_imag,
  input  norm_kind_t           kind,
  input  logic [ROW_CNT_W-1:0] row_count,
  input  logic [COL_CNT_W-1:0] col_count,
  input  logic                 q_full,
  output logic                 q_push,
  output logic [ACC_W-1:0]     q_sq,
  output mne_tag_t             q_tag,
  output logic [RW-1:0]        q_row
);

  localparam int LIM_W = $clog2(MAX_ROWS + 1);
  localparam int CW    = ((LIM_W > ROW_CNT_W) ? LIM_W : ROW_CNT_W) + 1;

  front_state_t         state_r, state_nxt;
  logic [RW-1:0]        row_pos_r, row_pos_nxt;
  logic [COL_CNT_W-1:0] col_pos_r, col_pos_nxt;
  logic [ELEM_W-1:0]    ar_r, ai_r;
  logic [ACC_W-1:0]     pa_r, pb_r;
  mne_tag_t             tag_r;
  logic [RW-1:0]        row_r;
  logic [CW-1:0]        rows_eff;
  logic [COL_CNT_W-1:0] cols_eff;
  logic                 last_row, last_col;
  logic                 accept;
  logic [ELEM_W-1:0]    abs_re, abs_im;

  // Effective matrix size: zero counts as one, rows clip at the store depth.
  always_comb begin
    rows_eff = CW'(row_count);
    if (rows_eff == '0) begin
      rows_eff = CW'(1);
    end else if (rows_eff > CW'(MAX_ROWS)) begin
      rows_eff = CW'(MAX_ROWS);
    end
    cols_eff = (col_count == '0) ? COL_CNT_W'(1) : col_count;
  end

  assign last_row = (CW'(row_pos_r) >= rows_eff - CW'(1));
  assign last_col = (col_pos_r >= cols_eff - COL_CNT_W'(1));

  // Magnitudes of the parts; the most negative value maps to 2^31.
  assign abs_re = in_elem_real[ELEM_W-1] ? (~in_elem_real + ELEM_W'(1)) : in_elem_real;
  assign abs_im = in_elem_imag[ELEM_W-1] ? (~in_elem_imag + ELEM_W'(1)) : in_elem_imag;

  assign in_ready = (state_r == FR_IDLE);
  assign accept   = in_valid && in_ready;
  assign q_push   = (state_r == FR_PUSH) && !q_full;
  assign q_sq     = pa_r + pb_r;
  assign q_tag    = tag_r;
  assign q_row    = row_r;

  // Sequencer and matrix position.
  always_comb begin
    state_nxt   = state_r;
    row_pos_nxt = row_pos_r;
    col_pos_nxt = col_pos_r;
    case (state_r)
      FR_IDLE: begin
        if (accept) begin
          state_nxt = FR_MUL;
          if (!last_row) begin
            row_pos_nxt = row_pos_r + RW'(1);
          end else begin
            row_pos_nxt = '0;
            col_pos_nxt = last_col ? '0 : col_pos_r + COL_CNT_W'(1);
          end
        end
      end
      FR_MUL: begin
        state_nxt = FR_PUSH;
      end
      FR_PUSH: begin
        if (!q_full) begin
          state_nxt = FR_IDLE;
        end
      end
      default: begin
        state_nxt = FR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= FR_IDLE;
      row_pos_r <= '0;
      col_pos_r <= '0;
    end else begin
      state_r   <= state_nxt;
      row_pos_r <= row_pos_nxt;
      col_pos_r <= col_pos_nxt;
    end
  end

  // Operand capture and the registered squares.
  always_ff @(posedge clk) begin
    if (accept) begin
      ar_r           <= abs_re;
      ai_r           <= abs_im;
      tag_r.kind     <= kind;
      tag_r.last_row <= last_row;
      tag_r.last_col <= last_col;
      tag_r.col_zero <= (col_pos_r == '0);
      row_r          <= row_pos_r;
    end
    if (state_r == FR_MUL) begin
      pa_r <= ar_r * ar_r;
      pb_r <= ai_r * ai_r;
    end
  end

endmodule

// File: design/mne_back.sv
module mne_back import mne_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int RW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  output logic             q_pop,
  input  logic [ACC_W-1:0] q_sq,
  input  mne_tag_t         q_tag,
  input  logic [RW-1:0]    q_row,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ACC_W-1:0] out_norm_value,
  output logic             out_saturated
);

  back_state_t      state_r, state_nxt;
  logic [ACC_W-1:0] sq_r;
  mne_tag_t         tag_r;
  logic [RW-1:0]    row_r;
  logic [ACC_W-1:0] mag_r, mag_nxt;
  logic [ACC_W-1:0] col_sum_r, col_sum_nxt;
  logic [ACC_W-1:0] best_r, best_nxt;
  logic [ACC_W-1:0] sqsum_r, sqsum_nxt;
  logic             ovf_r, ovf_nxt;
  logic [ACC_W-1:0] res_r, res_nxt;
  logic             res_sat_r, res_sat_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [ACC_W-1:0] out_val_r;
  logic             out_sat_r;
  logic             out_load;

  logic              sq_start, sq_busy, sq_done;
  logic [ACC_W-1:0]  sq_value;
  logic [ROOT_W-1:0] sq_root;

  logic             ram_we;
  logic [ACC_W-1:0] ram_wdata, ram_rdata;

  logic [ACC_W:0]   sum_one, sum_inf, sum_frob;
  logic [ACC_W-1:0] sat_one, sat_inf, sat_frob, row_val;
  logic             hit;
  logic             end_mat;

  mne_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .value (sq_value),
    .busy  (sq_busy),
    .done  (sq_done),
    .root  (sq_root)
  );

  mne_ram #(
    .WIDTH (ACC_W),
    .DEPTH (MAX_ROWS),
    .AW    (RW)
  ) u_row_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (row_r),
    .wdata (ram_wdata),
    .re    (q_pop),
    .raddr (q_row),
    .rdata (ram_rdata)
  );

  // Saturating sums for each accumulator.
  assign sum_one  = {1'b0, col_sum_r} + {1'b0, mag_r};
  assign sum_inf  = {1'b0, ram_rdata} + {1'b0, mag_r};
  assign sum_frob = {1'b0, sqsum_r} + {1'b0, sq_r};
  assign sat_one  = sum_one[ACC_W] ? '1 : sum_one[ACC_W-1:0];
  assign sat_inf  = sum_inf[ACC_W] ? '1 : sum_inf[ACC_W-1:0];
  assign sat_frob = sum_frob[ACC_W] ? '1 : sum_frob[ACC_W-1:0];
  assign row_val  = tag_r.col_zero ? mag_r : sat_inf;
  assign end_mat  = tag_r.last_row && tag_r.last_col;
  assign out_load = (state_r == BK_EMIT) && (!out_valid_r || out_ready);

  // Element sequencing: fetch, magnitude, accumulate, final root, emit.
  always_comb begin
    state_nxt     = state_r;
    q_pop         = 1'b0;
    sq_start      = 1'b0;
    sq_value      = q_sq;
    mag_nxt       = mag_r;
    col_sum_nxt   = col_sum_r;
    best_nxt      = best_r;
    sqsum_nxt     = sqsum_r;
    ovf_nxt       = ovf_r;
    res_nxt       = res_r;
    res_sat_nxt   = res_sat_r;
    ram_we        = 1'b0;
    ram_wdata     = row_val;
    hit           = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_tag.kind == KIND_FROB) begin
            state_nxt = BK_ACC;
          end else begin
            sq_start  = 1'b1;
            state_nxt = BK_MAG;
          end
        end
      end
      BK_MAG: begin
        if (sq_done) begin
          mag_nxt   = ACC_W'(sq_root);
          state_nxt = BK_ACC;
        end
      end
      BK_ACC: begin
        case (tag_r.kind)
          KIND_MAX: begin
            if (mag_r > best_r) begin
              best_nxt = mag_r;
            end
          end
          KIND_ONE: begin
            hit         = sum_one[ACC_W];
            col_sum_nxt = sat_one;
            if (tag_r.last_row) begin
              if (sat_one > best_r) begin
                best_nxt = sat_one;
              end
              col_sum_nxt = '0;
            end
          end
          KIND_INF: begin
            hit    = !tag_r.col_zero && sum_inf[ACC_W];
            ram_we = 1'b1;
            if (tag_r.last_col && row_val > best_r) begin
              best_nxt = row_val;
            end
          end
          default: begin
            hit       = sum_frob[ACC_W];
            sqsum_nxt = sat_frob;
          end
        endcase
        ovf_nxt = ovf_r || hit;
        if (end_mat) begin
          res_nxt     = best_nxt;
          res_sat_nxt = ovf_nxt;
          col_sum_nxt = '0;
          best_nxt    = '0;
          sqsum_nxt   = '0;
          ovf_nxt     = 1'b0;
          if (tag_r.kind == KIND_FROB) begin
            sq_start  = 1'b1;
            sq_value  = sat_frob;
            state_nxt = BK_FROB;
          end else begin
            state_nxt = BK_EMIT;
          end
        end else begin
          state_nxt = BK_IDLE;
        end
      end
      BK_FROB: begin
        if (sq_done) begin
          res_nxt   = ACC_W'(sq_root);
          state_nxt = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      col_sum_r   <= '0;
      best_r      <= '0;
      sqsum_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_sum_r   <= col_sum_nxt;
      best_r      <= best_nxt;
      sqsum_r     <= sqsum_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working copy of the popped entry and the result registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      sq_r  <= q_sq;
      tag_r <= q_tag;
      row_r <= q_row;
    end
    mag_r     <= mag_nxt;
    res_r     <= res_nxt;
    res_sat_r <= res_sat_nxt;
    if (out_load) begin
      out_val_r <= res_r;
      out_sat_r <= res_sat_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_norm_value = out_val_r;
  assign out_saturated  = out_sat_r;

  // The queue is only drained between elements.
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == BK_IDLE))
    else $error("queue popped while an element is in progress");

  // The shared root unit is never restarted mid-run.
  a_sqrt_free: assert property (@(posedge clk) disable iff (!rst_n)
    sq_start |-> !sq_busy)
    else $error("square root started while busy");

  // A finished root is only ever expected while waiting for one.
  a_sqrt_done: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> (state_r == BK_MAG || state_r == BK_FROB))
    else $error("square root finished with nobody waiting");

  // The row-sum store is written only for the infinity norm.
  a_ram_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == BK_ACC && tag_r.kind == KIND_INF))
    else $error("row-sum store written outside an infinity-norm update");

endmodule

// File: design/matrix_norm_engine.sv
// Channel  Handshake                Payload
// in       in_valid / in_ready      in_elem_real, in_elem_imag (signed Q15.16)
// out      out_valid / out_ready    out_norm_value (Q48.16), out_saturated
// cfg      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// The front end captures, squares and queues an element before the next one;
// the queue push waits while the queue is full. For the max, one and infinity
// norms each element then waits in the back end for the shared 32-step
// square-root unit; Frobenius elements skip it, and only the final root uses it.
// Reset is synchronous and active low; the row-sum store has no clearing pass.
// A waiting result stalls the back end first; once the 2-entry queue and the
// element held in the front are full, in_ready stays low as well.
module matrix_norm_engine import mne_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ELEM_W-1:0]     in_elem_real,
  input  logic [ELEM_W-1:0]     in_elem_imag,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ACC_W-1:0]      out_norm_value,
  output logic                  out_saturated,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int QW  = ACC_W + TAG_W + RW;

  norm_kind_t           kind_r, kind_nxt;
  logic [ROW_CNT_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [COL_CNT_W-1:0] col_cnt_r, col_cnt_nxt;

  logic             q_push, q_full, q_pop, q_empty;
  logic [ACC_W-1:0] f_sq, b_sq;
  mne_tag_t         f_tag, b_tag;
  logic [RW-1:0]    f_row, b_row;
  logic [QW-1:0]    q_din, q_dout;

  // Configuration registers; unmapped indexes are ignored.
  assign cfg_ready = 1'b1;

  always_comb begin
    kind_nxt    = kind_r;
    row_cnt_nxt = row_cnt_r;
    col_cnt_nxt = col_cnt_r;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_NORM_KIND: kind_nxt    = norm_kind_t'(cfg_data[KIND_W-1:0]);
        REG_ROW_COUNT: row_cnt_nxt = cfg_data[ROW_CNT_W-1:0];
        REG_COL_COUNT: col_cnt_nxt = cfg_data[COL_CNT_W-1:0];
        default: begin
          kind_nxt = kind_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r    <= KIND_MAX;
      row_cnt_r <= ROW_CNT_W'(1);
      col_cnt_r <= COL_CNT_W'(1);
    end else begin
      kind_r    <= kind_nxt;
      row_cnt_r <= row_cnt_nxt;
      col_cnt_r <= col_cnt_nxt;
    end
  end

  mne_front #(
    .MAX_ROWS (MAX_ROWS),
    .RW       (RW)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_elem_real (in_elem_real),
    .in_elem_imag (in_elem_imag),
    .kind         (kind_r),
    .row_count    (row_cnt_r),
    .col_count    (col_cnt_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_sq         (f_sq),
    .q_tag        (f_tag),
    .q_row        (f_row)
  );

  assign q_din = {f_sq, f_tag, f_row};

  mne_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign {b_sq, b_tag, b_row} = q_dout;

  mne_back #(
    .MAX_ROWS (MAX_ROWS),
    .RW       (RW)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .q_sq           (b_sq),
    .q_tag          (b_tag),
    .q_row          (b_row),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_norm_value (out_norm_value),
    .out_saturated  (out_saturated)
  );

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import mne_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 200;
  localparam int ITEM_TARGET = 700;

  // Norm predictor and store of expected norms.
  class norm_scoreboard;
    norm_kind_t  kind;
    int unsigned rows_raw;
    int unsigned cols_raw;
    logic [63:0] row_acc [MAX_ROWS_DEF];
    int unsigned row_pos;
    int unsigned col_pos;
    logic [63:0] col_acc;
    logic [63:0] best;
    logic [63:0] sq_acc;
    bit          sat_seen;
    logic [63:0] want_norm [$];
    bit          want_sat [$];
    string       msg;

    function new();
      kind = KIND_MAX;
      rows_raw = 1;
      cols_raw = 1;
      row_pos = 0;
      col_pos = 0;
      col_acc = '0;
      best = '0;
      sq_acc = '0;
      sat_seen = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [15:0] data);
      case (idx)
        REG_NORM_KIND: kind = norm_kind_t'(data[1:0]);
        REG_ROW_COUNT: rows_raw = data[10:0];
        REG_COL_COUNT: cols_raw = data;
        default: ;
      endcase
    endfunction

    function logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int i = 31; i >= 0; i--) begin
        trial = root | (64'd1 << i);
        if (trial * trial <= v) root = trial;
      end
      return root;
    endfunction

    function logic [63:0] magnitude32(logic [31:0] x);
      if (x[31]) return 64'd0 + ((~{1'b0, x}) + 33'd1) & 33'h0_ffff_ffff |
                        (x == 32'h8000_0000 ? 64'h8000_0000 : 64'd0);
      return {32'd0, x};
    endfunction

    function logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, inout bit hit);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s[64]) begin
        hit = 1;
        return '1;
      end
      return s[63:0];
    endfunction

    // Accepted element beat: advance the predictor, maybe queue a norm.
    function void note_elem(logic [31:0] re, logic [31:0] im);
      logic [63:0] ar, ai, sq, mag, v;
      int unsigned rows, cols, idx;
      bit last_row, last_col, hit;
      ar = magnitude32(re);
      ai = magnitude32(im);
      sq = ar * ar + ai * ai;
      mag = root_floor(sq);
      rows = (rows_raw == 0) ? 1 : (rows_raw > MAX_ROWS_DEF ? MAX_ROWS_DEF : rows_raw);
      cols = (cols_raw == 0) ? 1 : cols_raw;
      last_row = row_pos >= rows - 1;
      last_col = col_pos >= cols - 1;
      hit = 0;
      case (kind)
        KIND_MAX: if (mag > best) best = mag;
        KIND_ONE: begin
          col_acc = sat_add(col_acc, mag, hit);
          if (last_row) begin
            if (col_acc > best) best = col_acc;
            col_acc = '0;
          end
        end
        KIND_INF: begin
          idx = (row_pos < MAX_ROWS_DEF) ? row_pos : MAX_ROWS_DEF - 1;
          v = (col_pos == 0) ? mag : sat_add(row_acc[idx], mag, hit);
          row_acc[idx] = v;
          if (last_col && v > best) best = v;
        end
        default: sq_acc = sat_add(sq_acc, sq, hit);
      endcase
      if (hit) sat_seen = 1;
      if (!last_row) begin
        row_pos++;
        return;
      end
      row_pos = 0;
      if (!last_col) begin
        col_pos++;
        return;
      end
      col_pos = 0;
      want_norm.push_back(kind == KIND_FROB ? root_floor(sq_acc) : best);
      want_sat.push_back(sat_seen);
      col_acc = '0;
      best = '0;
      sq_acc = '0;
      sat_seen = 0;
    endfunction

    // Compare one result beat with the oldest expected norm.
    function bit check_norm(logic [63:0] got_norm, logic got_sat);
      logic [63:0] n;
      bit s;
      if (want_norm.size() == 0) begin
        msg = $sformatf("unexpected result norm=%h sat=%b", got_norm, got_sat);
        return 0;
      end
      n = want_norm.pop_front();
      s = want_sat.pop_front();
      msg = "";
      if (got_norm !== n)
        msg = $sformatf("norm_value got %h want %h", got_norm, n);
      if (got_sat !== s)
        msg = {msg, $sformatf(" saturated got %b want %b", got_sat, s)};
      return msg == "";
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_elem_real;
  logic [31:0] in_elem_imag;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_norm_value;
  logic        out_saturated;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  norm_scoreboard sb;
  int errors;
  int cycles;
  int items_sent;
  int norms_seen;
  bit hold_go;

  matrix_norm_engine uut (.*);

  // Clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Cycle count and run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic report(string what);
    $display("mismatch @%0d: %s", cycles, what);
    errors++;
  endtask

  // Idle with a chance of 9 in a hundred, except in a quiet window.
  function automatic bit want_gap();
    if (cycles > 3000 && cycles < 9000) return 0;
    return $urandom_range(99) < 9;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [15:0] data);
    bit ok;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    sb.set_reg(idx, data);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_elem(logic [31:0] re, logic [31:0] im);
    bit ok;
    while (want_gap()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_elem_real <= re;
    in_elem_imag <= im;
    do begin
      @(negedge clk);
      ok = in_ready;
      @(posedge clk);
    end while (!ok);
    sb.note_elem(re, im);
    items_sent++;
  endtask

  // Wait for every expected norm, then let the back end drain.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.want_norm.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(norm_kind_t k, logic [15:0] rows, logic [15:0] cols);
    write_reg(REG_NORM_KIND, k);
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_COL_COUNT, cols);
  endtask

  function automatic logic [31:0] rand_part();
    logic [31:0] v;
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'h0;
          default: v = 32'hffff_ffff;
        endcase
      end
      1: begin
        v = $urandom_range(32'h3ffff);
        if ($urandom_range(1)) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) send_elem(rand_part(), rand_part());
  endtask

  // Result side: random back-pressure plus one long hold.
  initial begin
    bit held;
    int hold;
    held = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!held && hold_go && norms_seen >= 5) begin
        held = 1;
        out_ready <= 1'b0;
        for (hold = 0; hold < 400; hold++) @(posedge clk);
      end
      out_ready <= !want_gap();
      @(negedge clk);
      if (out_valid && out_ready) begin
        norms_seen++;
        if (!sb.check_norm(out_norm_value, out_saturated)) report(sb.msg);
      end
    end
  end

  // Stimulus.
  initial begin
    int rows, cols, mats;
    sb = new();
    errors = 0;
    cycles = 0;
    items_sent = 0;
    norms_seen = 0;
    hold_go = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_elem_real = '0;
    in_elem_imag = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_NORM_KIND;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme elements one by one under the max norm.
    configure(KIND_MAX, 1, 1);
    send_elem(32'h8000_0000, 32'h8000_0000);
    send_elem(32'h7fff_ffff, 32'h7fff_ffff);
    send_elem(32'h0, 32'h0);
    send_elem(32'h8000_0000, 32'h0);
    send_elem(32'hffff_ffff, 32'h1);
    drain();

    // Zero counts are taken as one; the widest column count is written too.
    configure(KIND_ONE, 0, 16'hffff);
    write_reg(REG_COL_COUNT, 0);
    send_elem(32'h0001_0000, 32'hffff_0000);
    send_elem(32'h7fff_ffff, 32'h8000_0000);
    drain();

    configure(KIND_ONE, 2, 2);
    send_random(4);
    drain();
    configure(KIND_INF, 3, 2);
    send_random(6);
    drain();

    // Two largest elements overflow the Frobenius sum.
    configure(KIND_FROB, 2, 1);
    send_elem(32'h8000_0000, 32'h8000_0000);
    send_elem(32'h8000_0000, 32'h8000_0000);
    drain();

    // Results are held back for a long stretch while one-element matrices
    // keep coming, so the queue fills and the input stalls.
    configure(KIND_MAX, 1, 1);
    hold_go = 1'b1;
    send_random(12);
    drain();

    // Random matrices, mostly small.
    while (items_sent < ITEM_TARGET) begin
      rows = $urandom_range(1, 5);
      cols = $urandom_range(1, 4);
      if ($urandom_range(9) == 0) begin
        rows = $urandom_range(6, 40);
        mats = 1;
      end else begin
        mats = $urandom_range(1, 6);
      end
      configure(norm_kind_t'($urandom_range(3)), 16'(rows), 16'(cols));
      send_random(mats * rows * cols);
      drain();
    end

    if (sb.want_norm.size() != 0) report("expected norms left over");
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
